@@ rtl/tfc_pkg.sv @@
// Shared types and constants for the transfer-function classifier.
// Action codes, configuration register indexes and fixed field widths.
// No dependencies.
package tfc_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 33;
  localparam int INV_W      = 48;
  localparam int COUNT_W    = 9;
  localparam int CHAN_W     = 16;
  localparam int ENTRY_W    = 8;
  localparam int ACTION_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Action codes carried on the input channel
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_COLOR   = 2'd0,
    ACT_LOAD_OPACITY = 2'd1,
    ACT_CLASSIFY     = 2'd2,
    ACT_NONE         = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_MIN     = 2'd0,
    CFG_INV_RANGE     = 2'd1,
    CFG_COLOR_COUNT   = 2'd2,
    CFG_OPACITY_COUNT = 2'd3
  } cfg_reg_t;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] RANGE_MIN_RST = '0;
  localparam logic [INV_W-1:0]    INV_RANGE_RST = 48'h0001_0000_0000;
  localparam logic [COUNT_W-1:0]  COUNT_RST     = 9'd1;

endpackage

@@ rtl/tfc_in_if.sv @@
// Input channel of the classifier: valid/ready plus one action beat.
// Depends on tfc_pkg for the field widths.
interface tfc_in_if;
  import tfc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [SAMPLE_W-1:0] sample;
  logic [ENTRY_W-1:0]         entry_index;
  logic [CHAN_W-1:0]          entry_red;
  logic [CHAN_W-1:0]          entry_green;
  logic [CHAN_W-1:0]          entry_blue;
  logic [CHAN_W-1:0]          entry_opacity;

  modport source (
    output valid, action, sample, entry_index, entry_red, entry_green, entry_blue,
           entry_opacity,
    input  ready
  );

  modport sink (
    input  valid, action, sample, entry_index, entry_red, entry_green, entry_blue,
           entry_opacity,
    output ready
  );

endinterface

@@ rtl/tfc_out_if.sv @@
// Result channel of the classifier: valid/ready plus one classified beat.
// Depends on tfc_pkg; NORM_W must be FRAC_BITS + 1 of the classifier.
interface tfc_out_if #(
  parameter int NORM_W = 17
);
  import tfc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] opacity;
  logic [NORM_W-1:0] normalized;

  modport source (
    output valid, red, green, blue, opacity, normalized,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue, opacity, normalized,
    output ready
  );

endinterface

@@ rtl/tfc_table.sv @@
// Lookup table memory: one write port, two synchronous read ports.
// Read data is registered and holds while the read enable is low. No package use.
module tfc_table #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // two read ports, read data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/transfer_function_classifier_top.sv @@
// Transfer-function classifier top level: normalisation, table lookup, blend.
// Depends on tfc_pkg, tfc_in_if, tfc_out_if and tfc_table.
//
// Usage:
//   in_ch carries one action per beat: load a colour entry, load an opacity
//   entry, or classify a sample. Load beats write the tables and give no
//   result; a classify beat gives exactly one beat on out_ch with the
//   interpolated colour, opacity and the clamped normalised sample.
//   The cfg_ port writes one of range_min, inv_range and the two entry counts,
//   selected by cfg_index; write it only while the block is idle.
//   Path: a classify beat accepted on in_ch passes stages 1 to 5 in order and
//   is offered on out_ch from the stage 5 register. Throughput: one beat per
//   cycle while out_ch does not stall, set by the five-stage pipeline whose
//   table stage does both reads of each table on the two ports of its memory.
//   Loads write the tables in the same stage where classifies read them, so
//   every beat sees the tables as left by the beats before it.
//   Reset clears the pipeline and loads the default configuration; table
//   contents are undefined until written.
//   When out_ch stalls, the result holds and empty stages still fill; in_ch
//   ready falls only once all five stages hold a beat.
module transfer_function_classifier_top #(
  parameter int TABLE_DEPTH = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tfc_in_if.sink                             in_ch,
  tfc_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tfc_pkg::*;

  localparam int IW     = $clog2(TABLE_DEPTH);
  localparam int NORM_W = FRAC_BITS + 1;
  localparam int SC_W   = FRAC_BITS + IW;
  localparam int COL_W  = 3 * CHAN_W;
  localparam logic [NORM_W-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [SAMPLE_W-1:0] range_min_r;
  logic [INV_W-1:0]    inv_range_r;
  logic [COUNT_W-1:0]  color_count_r;
  logic [COUNT_W-1:0]  opacity_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r     <= RANGE_MIN_RST;
      inv_range_r     <= INV_RANGE_RST;
      color_count_r   <= COUNT_RST;
      opacity_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_RANGE_MIN:     range_min_r     <= cfg_data[SAMPLE_W-1:0];
        CFG_INV_RANGE:     inv_range_r     <= cfg_data[INV_W-1:0];
        CFG_COLOR_COUNT:   color_count_r   <= cfg_data[COUNT_W-1:0];
        CFG_OPACITY_COUNT: opacity_count_r <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // last usable entry: count clamped to [1, TABLE_DEPTH], minus one
  function automatic logic [IW-1:0] last_entry(input logic [COUNT_W-1:0] cnt);
    logic [IW-1:0] r;
    if (cnt == '0) begin
      r = '0;
    end else if (32'(cnt) > 32'(TABLE_DEPTH)) begin
      r = IW'(TABLE_DEPTH - 1);
    end else begin
      r = IW'(cnt - 1'b1);
    end
    return r;
  endfunction

  logic [IW-1:0] last_c;
  logic [IW-1:0] last_o;

  assign last_c = last_entry(color_count_r);
  assign last_o = last_entry(opacity_count_r);

  // linear blend a + floor(frac * (b - a) / one)
  function automatic logic [CHAN_W-1:0] blend(input logic [FRAC_BITS-1:0] frac,
                                              input logic [CHAN_W-1:0]    a,
                                              input logic [CHAN_W-1:0]    b);
    logic signed [CHAN_W:0]             dlt;
    logic signed [CHAN_W+FRAC_BITS+1:0] prod;
    logic signed [CHAN_W+FRAC_BITS+1:0] shd;
    dlt  = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = dlt * $signed({1'b0, frac});
    shd  = prod >>> FRAC_BITS;
    return a + shd[CHAN_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage takes a beat when empty or when it moves on
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_fire;

  assign rdy5 = !s5_v_r || out_ch.ready;
  assign rdy4 = !s4_v_r || rdy5;
  assign rdy3 = !s3_v_r || rdy4;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;

  assign in_ch.ready = rdy1;
  assign in_fire     = in_ch.valid && rdy1;

  // ---------------------------------------------------------------------------
  // Stage 1: sample minus range_min
  logic [ACTION_W-1:0]  s1_act_r;
  logic signed [SAMPLE_W:0] s1_diff_r;
  logic [ENTRY_W-1:0]   s1_idx_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [CHAN_W-1:0]    s1_opa_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_act_r  <= in_ch.action;
      s1_diff_r <= $signed({in_ch.sample[SAMPLE_W-1], in_ch.sample})
                 - $signed({range_min_r[SAMPLE_W-1], range_min_r});
      s1_idx_r  <= in_ch.entry_index;
      s1_col_r  <= {in_ch.entry_red, in_ch.entry_green, in_ch.entry_blue};
      s1_opa_r  <= in_ch.entry_opacity;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: product with the low word of inv_range, saturation flags
  logic                diff_le0;
  logic                ih_nz;
  logic                il_z;
  logic [63:0]         prod_nxt;
  logic [ACTION_W-1:0] s2_act_r;
  logic                s2_zero_r;
  logic                s2_one_r;
  logic [63:0]         s2_prod_r;
  logic [ENTRY_W-1:0]  s2_idx_r;
  logic [COL_W-1:0]    s2_col_r;
  logic [CHAN_W-1:0]   s2_opa_r;

  assign diff_le0 = s1_diff_r[SAMPLE_W] || (s1_diff_r == '0);
  assign ih_nz    = (inv_range_r[INV_W-1:32] != '0);
  assign il_z     = (inv_range_r[31:0] == '0);
  assign prod_nxt = s1_diff_r[31:0] * inv_range_r[31:0];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_act_r  <= s1_act_r;
      s2_zero_r <= diff_le0 || (!ih_nz && il_z);
      s2_one_r  <= ih_nz || (s1_diff_r[SAMPLE_W-1:32] != '0);
      s2_prod_r <= prod_nxt;
      s2_idx_r  <= s1_idx_r;
      s2_col_r  <= s1_col_r;
      s2_opa_r  <= s1_opa_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: clamp to [0,1], scale by entry count minus one
  logic [NORM_W-1:0]   norm_nxt;
  logic [SC_W:0]       scl_c_nxt;
  logic [SC_W:0]       scl_o_nxt;
  logic [ACTION_W-1:0] s3_act_r;
  logic [NORM_W-1:0]   s3_norm_r;
  logic [SC_W-1:0]     s3_scl_c_r;
  logic [SC_W-1:0]     s3_scl_o_r;
  logic [ENTRY_W-1:0]  s3_idx_r;
  logic [COL_W-1:0]    s3_col_r;
  logic [CHAN_W-1:0]   s3_opa_r;

  always_comb begin
    if (s2_zero_r) begin
      norm_nxt = '0;
    end else if (s2_one_r || (s2_prod_r[63:32] != '0)) begin
      norm_nxt = ONE_FIX;
    end else begin
      norm_nxt = {1'b0, s2_prod_r[31:32-FRAC_BITS]};
    end
  end

  // normalised value never exceeds one, so the top product bit is always clear
  assign scl_c_nxt = norm_nxt * last_c;
  assign scl_o_nxt = norm_nxt * last_o;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_act_r   <= s2_act_r;
      s3_norm_r  <= norm_nxt;
      s3_scl_c_r <= scl_c_nxt[SC_W-1:0];
      s3_scl_o_r <= scl_o_nxt[SC_W-1:0];
      s3_idx_r   <= s2_idx_r;
      s3_col_r   <= s2_col_r;
      s3_opa_r   <= s2_opa_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 -> 4: table reads for classify beats, table writes for loads
  logic [IW-1:0] i0_c, i1_c, i0_o, i1_o;
  logic          idx_ok;
  logic          cls_go;
  logic          col_we;
  logic          opa_we;
  logic [IW-1:0] waddr;

  assign i0_c   = s3_scl_c_r[SC_W-1:FRAC_BITS];
  assign i1_c   = i0_c + IW'(i0_c != last_c);
  assign i0_o   = s3_scl_o_r[SC_W-1:FRAC_BITS];
  assign i1_o   = i0_o + IW'(i0_o != last_o);

  assign idx_ok = (32'(s3_idx_r) < 32'(TABLE_DEPTH));
  assign waddr  = IW'(s3_idx_r);
  assign cls_go = rdy4 && s3_v_r && (action_t'(s3_act_r) == ACT_CLASSIFY);
  assign col_we = rdy4 && s3_v_r && idx_ok && (action_t'(s3_act_r) == ACT_LOAD_COLOR);
  assign opa_we = rdy4 && s3_v_r && idx_ok && (action_t'(s3_act_r) == ACT_LOAD_OPACITY);

  logic [COL_W-1:0]  col_a, col_b;
  logic [CHAN_W-1:0] opa_a, opa_b;

  tfc_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (COL_W)
  ) u_color_table (
    .clk     (clk),
    .we      (col_we),
    .waddr   (waddr),
    .wdata   (s3_col_r),
    .re      (cls_go),
    .raddr_a (i0_c),
    .raddr_b (i1_c),
    .rdata_a (col_a),
    .rdata_b (col_b)
  );

  tfc_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (CHAN_W)
  ) u_opacity_table (
    .clk     (clk),
    .we      (opa_we),
    .waddr   (waddr),
    .wdata   (s3_opa_r),
    .re      (cls_go),
    .raddr_a (i0_o),
    .raddr_b (i1_o),
    .rdata_a (opa_a),
    .rdata_b (opa_b)
  );

  // Stage 4: fractions and normalised value beside the table data
  logic [FRAC_BITS-1:0] s4_frac_c_r;
  logic [FRAC_BITS-1:0] s4_frac_o_r;
  logic [NORM_W-1:0]    s4_norm_r;

  always_ff @(posedge clk) begin
    if (cls_go) begin
      s4_frac_c_r <= s3_scl_c_r[FRAC_BITS-1:0];
      s4_frac_o_r <= s3_scl_o_r[FRAC_BITS-1:0];
      s4_norm_r   <= s3_norm_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: blend into the output register
  logic [CHAN_W-1:0] s5_red_r, s5_green_r, s5_blue_r, s5_opa_r;
  logic [NORM_W-1:0] s5_norm_r;

  always_ff @(posedge clk) begin
    if (rdy5 && s4_v_r) begin
      s5_red_r   <= blend(s4_frac_c_r, col_a[3*CHAN_W-1:2*CHAN_W],
                          col_b[3*CHAN_W-1:2*CHAN_W]);
      s5_green_r <= blend(s4_frac_c_r, col_a[2*CHAN_W-1:CHAN_W],
                          col_b[2*CHAN_W-1:CHAN_W]);
      s5_blue_r  <= blend(s4_frac_c_r, col_a[CHAN_W-1:0], col_b[CHAN_W-1:0]);
      s5_opa_r   <= blend(s4_frac_o_r, opa_a, opa_b);
      s5_norm_r  <= s4_norm_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits; load and unused beats leave the pipeline at the table stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r <= in_fire;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= cls_go;
      if (rdy5) s5_v_r <= s4_v_r;
    end
  end

  assign out_ch.valid      = s5_v_r;
  assign out_ch.red        = s5_red_r;
  assign out_ch.green      = s5_green_r;
  assign out_ch.blue       = s5_blue_r;
  assign out_ch.opacity    = s5_opa_r;
  assign out_ch.normalized = s5_norm_r;

endmodule
